FILE: src/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types, constants and helpers for the max-XOR binary trie unit.
// ----------------------------------------------------------------------------
package btmx_pkg;

   // Port width of value and max_xor fields
   localparam int unsigned PORT_BITS  = 31;

   // Node store geometry: 15-bit pointers, two pointers per entry
   localparam int unsigned NODE_BITS  = 15;
   localparam int unsigned ENTRY_BITS = 30;
   localparam int unsigned NODE_DEPTH = 32768;

   typedef logic [NODE_BITS-1:0]  node_type;
   typedef logic [ENTRY_BITS-1:0] entry_type;

   // Allocation bound: new nodes stay below this index; root is node zero and never a child
   localparam node_type NODE_LIMIT = 15'h7FFF;
   localparam node_type ROOT_NODE  = 15'h0000;
   localparam node_type FIRST_FREE = 15'h0001;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHECK,
      ST_ATTACH,
      ST_NODES,
      ST_FINISH
   } state_type;

   // Node memory write port
   typedef struct packed {
      logic      en;
      node_type  addr;
      entry_type data;
   } wr_type;

   // Child pointer for branch bit b (zero means no child)
   function automatic node_type child_of(entry_type e, logic b);
      return b ? e[ENTRY_BITS-1:NODE_BITS] : e[NODE_BITS-1:0];
   endfunction

   // Entry with the pointer for branch bit b replaced
   function automatic entry_type set_child(entry_type e, logic b, node_type c);
      entry_type r;
      r = e;
      if (b) begin
         r[ENTRY_BITS-1:NODE_BITS] = c;
      end else begin
         r[NODE_BITS-1:0] = c;
      end
      return r;
   endfunction

endpackage

FILE: src/btmx_node_ram.sv
// ----------------------------------------------------------------------------
// btmx_node_ram
// Trie node store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module btmx_node_ram (
   input  logic                clock,
   input  btmx_pkg::wr_type    wr,
   input  btmx_pkg::node_type  rd_a_addr,
   input  btmx_pkg::node_type  rd_b_addr,
   output btmx_pkg::entry_type rd_a_data,
   output btmx_pkg::entry_type rd_b_data
);

   btmx_pkg::entry_type node_mem [btmx_pkg::NODE_DEPTH];
   btmx_pkg::entry_type rd_a_data_ff;
   btmx_pkg::entry_type rd_b_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         node_mem[wr.addr] <= wr.data;
      end
   end

   // Read ports, registered
   always_ff @(posedge clock) begin
      rd_a_data_ff <= node_mem[rd_a_addr];
      rd_b_data_ff <= node_mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

FILE: src/binary_trie_max_xor_unit.sv
// A beat is accepted only in idle; the next beat waits until the walk, any insert and the
// result hand-off of the previous beat are done.
// The walk reads one trie level per cycle on both node memory read ports; the insert
// writes one node per cycle through the single write port.
// Reset clears control, root and max; the node memory needs no clearing pass.
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit
// Largest XOR of any two values of a set. Each value is queried against a
// binary trie (greedy opposite-bit walk) and then inserted; the set result is
// given on the beat marked last, after which the trie is emptied.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit #(
   parameter int unsigned VALUE_BITS = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [btmx_pkg::PORT_BITS-1:0]    req_value,
   input  logic                              req_last_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [btmx_pkg::PORT_BITS-1:0]    rsp_max_xor,
   output logic                              rsp_overflow
);

   localparam int unsigned LVL_BITS  = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;
   localparam int unsigned NEED_BITS = $clog2(VALUE_BITS + 1);
   localparam logic [LVL_BITS-1:0] TOP_LVL = LVL_BITS'(VALUE_BITS - 1);

   // Control state
   btmx_pkg::state_type  state_ff,  state_in;
   btmx_pkg::entry_type  root_ff,   root_in;
   btmx_pkg::node_type   nf_ff,     nf_in;
   logic [VALUE_BITS-1:0] rmax_ff,  rmax_in;
   logic                 empty_ff,  empty_in;
   logic                 ovf_ff,    ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Per-beat payload / walk state
   logic [VALUE_BITS-1:0] v_ff,     v_in;
   logic                 last_ff,   last_in;
   logic [LVL_BITS-1:0]  lvl_ff,    lvl_in;
   btmx_pkg::node_type   a_node_ff, a_node_in;
   logic                 a_done_ff, a_done_in;
   logic [LVL_BITS-1:0]  miss_lvl_ff, miss_lvl_in;
   btmx_pkg::node_type   att_node_ff, att_node_in;
   btmx_pkg::entry_type  att_entry_ff, att_entry_in;
   logic                 b_stop_ff, b_stop_in;
   logic [VALUE_BITS-1:0] qx_ff,    qx_in;
   logic [LVL_BITS-1:0]  wl_ff,     wl_in;
   logic [btmx_pkg::PORT_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   // Memory interface
   btmx_pkg::wr_type     node_wr;
   btmx_pkg::node_type   rd_a_addr, rd_b_addr;
   btmx_pkg::entry_type  rd_a_data, rd_b_data;

   // Walk / check signals
   logic                 req_take;
   logic                 first_lvl;
   logic                 bit_v;
   btmx_pkg::entry_type  ent_a, ent_b;
   btmx_pkg::node_type   a_child, b_opp, b_same;
   logic [NEED_BITS-1:0] need;
   btmx_pkg::node_type   room;
   logic                 fits;
   logic                 rsp_free;
   btmx_pkg::entry_type  att_data, leaf_data;

   btmx_node_ram u_node_ram (
      .clock     (clock),
      .wr        (node_wr),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Level step: root comes from its register, deeper nodes from memory
   always_comb begin
      first_lvl = (lvl_ff == TOP_LVL);
      ent_a     = first_lvl ? root_ff : rd_a_data;
      ent_b     = first_lvl ? root_ff : rd_b_data;
      bit_v     = v_ff[lvl_ff];
      a_child   = btmx_pkg::child_of(ent_a, bit_v);
      b_opp     = btmx_pkg::child_of(ent_b, !bit_v);
      b_same    = btmx_pkg::child_of(ent_b, bit_v);
      rd_a_addr = a_child;
      rd_b_addr = (b_opp != btmx_pkg::ROOT_NODE) ? b_opp : b_same;
   end

   // Room check for the new branch
   always_comb begin
      need = a_done_ff ? (NEED_BITS'(miss_lvl_ff) + NEED_BITS'(1)) : '0;
      room = btmx_pkg::NODE_LIMIT - nf_ff;
      fits = (16'(need) <= 16'(room));
   end

   // Write data for the attach point and for each new node
   always_comb begin
      att_data  = btmx_pkg::set_child(att_entry_ff, v_ff[miss_lvl_ff], nf_ff);
      leaf_data = '0;
      if (wl_ff != '0) begin
         leaf_data = btmx_pkg::set_child('0, v_ff[LVL_BITS'(wl_ff - 1'b1)],
                                         nf_ff + btmx_pkg::FIRST_FREE);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         btmx_pkg::ST_IDLE: begin
            if (req_valid) state_in = btmx_pkg::ST_WALK;
         end
         btmx_pkg::ST_WALK: begin
            if (lvl_ff == '0) state_in = btmx_pkg::ST_CHECK;
         end
         btmx_pkg::ST_CHECK: begin
            state_in = (fits && a_done_ff) ? btmx_pkg::ST_ATTACH : btmx_pkg::ST_FINISH;
         end
         btmx_pkg::ST_ATTACH: begin
            state_in = btmx_pkg::ST_NODES;
         end
         btmx_pkg::ST_NODES: begin
            if (wl_ff == '0) state_in = btmx_pkg::ST_FINISH;
         end
         btmx_pkg::ST_FINISH: begin
            if (!last_ff || rsp_free) state_in = btmx_pkg::ST_IDLE;
         end
         default: state_in = btmx_pkg::ST_IDLE;
      endcase
   end

   // State outputs: handshake and memory write port
   always_comb begin
      req_stall    = 1'b1;
      node_wr      = '0;
      case (state_ff)
         btmx_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         btmx_pkg::ST_ATTACH: begin
            node_wr.en   = (att_node_ff != btmx_pkg::ROOT_NODE);
            node_wr.addr = att_node_ff;
            node_wr.data = att_data;
         end
         btmx_pkg::ST_NODES: begin
            node_wr.en   = 1'b1;
            node_wr.addr = nf_ff;
            node_wr.data = leaf_data;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      root_in      = root_ff;
      nf_in        = nf_ff;
      rmax_in      = rmax_ff;
      empty_in     = empty_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      lvl_in       = lvl_ff;
      a_node_in    = a_node_ff;
      a_done_in    = a_done_ff;
      miss_lvl_in  = miss_lvl_ff;
      att_node_in  = att_node_ff;
      att_entry_in = att_entry_ff;
      b_stop_in    = b_stop_ff;
      qx_in        = qx_ff;
      wl_in        = wl_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // result beat taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         btmx_pkg::ST_IDLE: begin
            if (req_take) begin
               v_in      = VALUE_BITS'(req_value);
               last_in   = req_last_item;
               lvl_in    = TOP_LVL;
               a_node_in = btmx_pkg::ROOT_NODE;
               a_done_in = 1'b0;
               b_stop_in = 1'b0;
               qx_in     = '0;
            end
         end
         btmx_pkg::ST_WALK: begin
            // insert path: find first missing child
            if (!a_done_ff) begin
               if (a_child == btmx_pkg::ROOT_NODE) begin
                  a_done_in    = 1'b1;
                  miss_lvl_in  = lvl_ff;
                  att_node_in  = a_node_ff;
                  att_entry_in = ent_a;
               end else begin
                  a_node_in = a_child;
               end
            end
            // query path: prefer opposite bit
            if (!b_stop_ff) begin
               if (b_opp != btmx_pkg::ROOT_NODE) begin
                  qx_in[lvl_ff] = 1'b1;
               end else if (b_same == btmx_pkg::ROOT_NODE) begin
                  b_stop_in = 1'b1;
               end
            end
            if (lvl_ff != '0) lvl_in = lvl_ff - 1'b1;
         end
         btmx_pkg::ST_CHECK: begin
            wl_in = miss_lvl_ff;
            if (!fits) begin
               ovf_in = 1'b1;
            end else begin
               if (!empty_ff && (qx_ff > rmax_ff)) rmax_in = qx_ff;
               empty_in = 1'b0;
            end
         end
         btmx_pkg::ST_ATTACH: begin
            if (att_node_ff == btmx_pkg::ROOT_NODE) root_in = att_data;
         end
         btmx_pkg::ST_NODES: begin
            nf_in = nf_ff + btmx_pkg::FIRST_FREE;
            if (wl_ff != '0) wl_in = wl_ff - 1'b1;
         end
         btmx_pkg::ST_FINISH: begin
            // last beat: publish and empty the set
            if (last_ff && rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = btmx_pkg::PORT_BITS'(rmax_ff);
               rsp_ovf_in   = ovf_ff;
               root_in      = '0;
               nf_in        = btmx_pkg::FIRST_FREE;
               rmax_in      = '0;
               empty_in     = 1'b1;
               ovf_in       = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btmx_pkg::ST_IDLE;
         root_ff      <= '0;
         nf_ff        <= btmx_pkg::FIRST_FREE;
         rmax_ff      <= '0;
         empty_ff     <= 1'b1;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         nf_ff        <= nf_in;
         rmax_ff      <= rmax_in;
         empty_ff     <= empty_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      last_ff      <= last_in;
      lvl_ff       <= lvl_in;
      a_node_ff    <= a_node_in;
      a_done_ff    <= a_done_in;
      miss_lvl_ff  <= miss_lvl_in;
      att_node_ff  <= att_node_in;
      att_entry_ff <= att_entry_in;
      b_stop_ff    <= b_stop_in;
      qx_ff        <= qx_in;
      wl_ff        <= wl_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_xor  = rsp_max_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // Root lives in a register; the memory is never written at node zero
   a_no_root_write: assert property (@(posedge clock) disable iff (reset)
      node_wr.en |-> (node_wr.addr != btmx_pkg::ROOT_NODE))
      else $error("node memory write to root");

   // Allocation only grows within a set
   a_nf_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff != btmx_pkg::ST_FINISH) |=> (nf_ff >= $past(nf_ff)))
      else $error("free node pointer went backward");

   // Publishing a result empties the set
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btmx_pkg::ST_FINISH && last_ff && rsp_free)
      |=> (rsp_valid_ff && nf_ff == btmx_pkg::FIRST_FREE && empty_ff && !ovf_ff))
      else $error("set not cleared after result");

endmodule
